>>> sv/ssra_pkg.sv
// Shared types and constants for the serial switch register access unit.
`default_nettype none

package ssra_pkg;

    // Request codes carried in the mode field.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_EDGE_TICKS  = 1'b0;
    localparam logic CFG_SETUP_TICKS = 1'b1;

    // Reset values of the timing registers.
    localparam logic [7:0] EDGE_TICKS_RESET  = 8'd3;
    localparam logic [7:0] SETUP_TICKS_RESET = 8'd1;

    // Frame lengths.
    localparam logic [5:0] READ_CMD_BITS  = 6'd46;
    localparam logic [5:0] WRITE_CMD_BITS = 6'd27;
    localparam logic [5:0] READ_DATA_BITS = 6'd32;
    localparam logic [5:0] EXTRA_CLOCKS   = 6'd2;

    // Command opcodes.
    localparam logic [2:0] WRITE_OPCODE = 3'b101;
    localparam logic [3:0] READ_OPCODE  = 4'b0110;
    localparam logic [31:0] READ_PREAMBLE = 32'hFFFF_FFFF;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Classified input item.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        table_select;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic        data_in;
    } entry_t;

    // One result item.
    typedef struct packed {
        logic        chip_select;
        logic        serial_clock;
        logic        data_out;
        logic        data_out_enable;
        logic        pins_enable;
        logic        busy_res;
        logic        done_res;
        logic [31:0] read_data;
        logic        rejected;
    } result_t;

    // Configuration write bundle.
    typedef struct packed {
        logic       write_enable;
        logic       index;
        logic [7:0] data;
    } cfg_write_t;

endpackage

`default_nettype wire

>>> sv/ssra_front.sv
// Front end: accepts input transfers, classifies them and queues them.
`default_nettype none

module ssra_front #(
    parameter int QUEUE_DEPTH = ssra_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [1:0]      mode,
    input  wire logic            table_select,
    input  wire logic [7:0]      reg_addr,
    input  wire logic [15:0]     write_data,
    input  wire logic            data_in,
    output logic                 head_valid,
    output ssra_pkg::entry_t     head,
    input  wire logic            pop
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCount = CntW'(QUEUE_DEPTH);

    ssra_pkg::entry_t queue_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    ssra_pkg::entry_t entry_c;
    logic push;

    // Classify the request; the unused mode code is a plain tick.
    always_comb
    begin
        entry_c.table_select = table_select;
        entry_c.reg_addr     = reg_addr;
        entry_c.write_data   = write_data;
        entry_c.data_in      = data_in;
        unique case (mode)
            ssra_pkg::MODE_READ:  entry_c.kind = ssra_pkg::KIND_READ;
            ssra_pkg::MODE_WRITE: entry_c.kind = ssra_pkg::KIND_WRITE;
            default:              entry_c.kind = ssra_pkg::KIND_TICK;
        endcase
    end

    // Queue handshake and pointer updates.
    assign in_stall   = (count_reg == FullCount);
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign head       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= entry_c;
        end
    end

endmodule

`default_nettype wire

>>> sv/ssra_back.sv
// Back end: pin sequencer that takes one queued tick a cycle while the output is not stalled, and registers its result.
`default_nettype none

module ssra_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ssra_pkg::cfg_write_t cfg,
    input  wire logic                head_valid,
    input  wire ssra_pkg::entry_t    head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ssra_pkg::result_t        res
);

    typedef enum logic [15:0] {
        PH_IDLE  = 16'h0001,
        PH_EN    = 16'h0002,
        PH_CSUP  = 16'h0004,
        PH_WLOW  = 16'h0008,
        PH_WSET  = 16'h0010,
        PH_WHIGH = 16'h0020,
        PH_TAIL  = 16'h0040,
        PH_REL   = 16'h0080,
        PH_PH    = 16'h0100,
        PH_PL    = 16'h0200,
        PH_RCS   = 16'h0400,
        PH_RLOW  = 16'h0800,
        PH_RHIGH = 16'h1000,
        PH_FH    = 16'h2000,
        PH_FL    = 16'h4000,
        PH_OFF   = 16'h8000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  tick_cnt_reg, tick_cnt_next;
    logic [45:0] cmd_reg, cmd_next;
    logic [31:0] read_shift_reg, read_shift_next;
    logic        is_write_reg, is_write_next;
    logic        table_reg, table_next;
    logic        addr_odd_reg, addr_odd_next;
    logic [7:0]  edge_ticks_reg;
    logic [7:0]  setup_ticks_reg;
    logic        out_valid_reg;
    ssra_pkg::result_t res_reg;
    ssra_pkg::result_t res_c;
    logic        active;
    logic        last;
    logic [7:0]  phase_len;
    logic [5:0]  total;
    logic [5:0]  bit_inc;

    // Number of command bits in the current frame.
    function automatic logic [5:0] cmd_total(input logic w);
        return w ? ssra_pkg::WRITE_CMD_BITS : ssra_pkg::READ_CMD_BITS;
    endfunction

    // Command bit k counted from the first bit sent; zero past the frame.
    function automatic logic cmd_bit(input logic [45:0] s, input logic w,
                                     input logic [5:0] k);
        logic [5:0] t;
        logic [5:0] idx;
        t   = cmd_total(w);
        idx = t - 6'd1 - k;
        if (k >= t)
        begin
            return 1'b0;
        end
        return s[idx];
    endfunction

    // A new tick is taken when the output register is free or being drained.
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // One sequencer step.
    always_comb
    begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        tick_cnt_next   = tick_cnt_reg;
        cmd_next        = cmd_reg;
        read_shift_next = read_shift_reg;
        is_write_next   = is_write_reg;
        table_next      = table_reg;
        addr_odd_next   = addr_odd_reg;
        res_c           = '0;
        active          = 1'b0;
        last            = 1'b0;
        phase_len       = 8'd1;
        total           = ssra_pkg::READ_CMD_BITS;
        bit_inc         = 6'd0;

        if (pop)
        begin
            active = 1'b1;
            // Start of a sequence: latch the request and build the command.
            if (phase_reg == PH_IDLE)
            begin
                if (head.kind == ssra_pkg::KIND_TICK)
                begin
                    active = 1'b0;
                end
                else
                begin
                    is_write_next = (head.kind == ssra_pkg::KIND_WRITE);
                    table_next    = head.table_select;
                    addr_odd_next = head.reg_addr[0];
                    if (is_write_next)
                    begin
                        cmd_next = {19'd0, ssra_pkg::WRITE_OPCODE, head.reg_addr,
                                    head.write_data};
                    end
                    else
                    begin
                        cmd_next = {ssra_pkg::READ_PREAMBLE, ssra_pkg::READ_OPCODE,
                                    head.table_select, 2'b00, head.reg_addr[6:0]};
                    end
                    read_shift_next = '0;
                    bit_cnt_next    = '0;
                    tick_cnt_next   = '0;
                    phase_next      = PH_EN;
                end
            end
            else
            begin
                res_c.rejected = (head.kind != ssra_pkg::KIND_TICK);
            end
        end

        if (active)
        begin
            total = cmd_total(is_write_next);
            res_c.busy_res        = 1'b1;
            res_c.pins_enable     = 1'b1;
            res_c.data_out_enable = 1'b1;

            // Pin levels for the current phase.
            unique case (phase_next)
                PH_EN:
                begin
                end
                PH_CSUP:
                begin
                    res_c.chip_select = is_write_next;
                end
                PH_WLOW:
                begin
                    res_c.chip_select = is_write_next;
                    res_c.data_out = (bit_cnt_next == '0) ? 1'b0 :
                        cmd_bit(cmd_next, is_write_next, bit_cnt_next - 6'd1);
                end
                PH_WSET:
                begin
                    res_c.chip_select = is_write_next;
                    res_c.data_out = cmd_bit(cmd_next, is_write_next, bit_cnt_next);
                end
                PH_WHIGH:
                begin
                    res_c.chip_select  = is_write_next;
                    res_c.serial_clock = 1'b1;
                    res_c.data_out = cmd_bit(cmd_next, is_write_next, bit_cnt_next);
                end
                PH_TAIL:
                begin
                    res_c.chip_select = is_write_next;
                    if (!is_write_next && bit_cnt_next != ssra_pkg::READ_CMD_BITS)
                    begin
                        res_c.data_out_enable = 1'b0;
                    end
                    else
                    begin
                        res_c.data_out = cmd_next[0];
                    end
                end
                PH_FH, PH_FL:
                begin
                    res_c.serial_clock = (phase_next == PH_FH);
                    if (is_write_next)
                    begin
                        res_c.data_out = cmd_next[0];
                    end
                    else
                    begin
                        res_c.data_out_enable = 1'b0;
                    end
                end
                PH_PH, PH_RHIGH:
                begin
                    res_c.serial_clock    = 1'b1;
                    res_c.data_out_enable = 1'b0;
                end
                PH_OFF:
                begin
                    res_c.pins_enable     = 1'b0;
                    res_c.data_out_enable = 1'b0;
                end
                default:
                begin
                    res_c.data_out_enable = 1'b0;
                end
            endcase

            // Phase timing; a zero register acts as one tick.
            phase_len = (phase_next == PH_WSET) ? setup_ticks_reg : edge_ticks_reg;
            if (phase_len == '0)
            begin
                phase_len = 8'd1;
            end
            last    = ({1'b0, tick_cnt_next} + 9'd1) >= {1'b0, phase_len};
            bit_inc = bit_cnt_next + 6'd1;

            if (!last)
            begin
                tick_cnt_next = tick_cnt_next + 8'd1;
            end
            else
            begin
                tick_cnt_next = '0;
                // Phase transitions at the end of each phase.
                unique case (phase_next)
                    PH_EN:   phase_next = PH_CSUP;
                    PH_CSUP:
                    begin
                        bit_cnt_next = '0;
                        phase_next   = PH_WLOW;
                    end
                    PH_WLOW: phase_next = PH_WSET;
                    PH_WSET: phase_next = PH_WHIGH;
                    PH_WHIGH:
                    begin
                        bit_cnt_next = bit_inc;
                        phase_next   = (bit_inc >= total) ? PH_TAIL : PH_WLOW;
                    end
                    PH_TAIL:
                    begin
                        if (!is_write_next && bit_cnt_next == ssra_pkg::READ_CMD_BITS)
                        begin
                            phase_next = PH_REL;
                        end
                        else
                        begin
                            bit_cnt_next = '0;
                            phase_next   = PH_FH;
                        end
                    end
                    PH_REL:
                    begin
                        bit_cnt_next = '0;
                        phase_next   = PH_PH;
                    end
                    PH_PH:   phase_next = PH_PL;
                    PH_PL:
                    begin
                        if (bit_inc >= ssra_pkg::EXTRA_CLOCKS)
                        begin
                            bit_cnt_next = '0;
                            phase_next   = PH_RCS;
                        end
                        else
                        begin
                            bit_cnt_next = bit_inc;
                            phase_next   = PH_PH;
                        end
                    end
                    PH_RCS:  phase_next = PH_RLOW;
                    PH_RLOW:
                    begin
                        // Data is sampled on the last tick of the low phase.
                        read_shift_next = {read_shift_next[30:0], head.data_in};
                        phase_next      = PH_RHIGH;
                    end
                    PH_RHIGH:
                    begin
                        bit_cnt_next = bit_inc;
                        phase_next   = (bit_inc >= ssra_pkg::READ_DATA_BITS) ?
                                       PH_TAIL : PH_RLOW;
                    end
                    PH_FH:   phase_next = PH_FL;
                    PH_FL:
                    begin
                        bit_cnt_next = bit_inc;
                        phase_next   = (bit_inc >= ssra_pkg::EXTRA_CLOCKS) ? PH_OFF : PH_FH;
                    end
                    default:
                    begin
                        // End of the sequence: report completion and read data.
                        res_c.done_res = 1'b1;
                        if (!is_write_next)
                        begin
                            if (table_next)
                            begin
                                res_c.read_data = read_shift_next;
                            end
                            else if (addr_odd_next)
                            begin
                                res_c.read_data = {16'd0, read_shift_next[31:16]};
                            end
                            else
                            begin
                                res_c.read_data = {16'd0, read_shift_next[15:0]};
                            end
                        end
                        bit_cnt_next = '0;
                        phase_next   = PH_IDLE;
                    end
                endcase
            end

            // Released data pin reads low.
            if (!res_c.data_out_enable)
            begin
                res_c.data_out = 1'b0;
            end
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= '0;
            tick_cnt_reg   <= '0;
            cmd_reg        <= '0;
            read_shift_reg <= '0;
            is_write_reg   <= 1'b0;
            table_reg      <= 1'b0;
            addr_odd_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            tick_cnt_reg   <= tick_cnt_next;
            cmd_reg        <= cmd_next;
            read_shift_reg <= read_shift_next;
            is_write_reg   <= is_write_next;
            table_reg      <= table_next;
            addr_odd_reg   <= addr_odd_next;
        end
    end

    // Timing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_ticks_reg  <= ssra_pkg::EDGE_TICKS_RESET;
            setup_ticks_reg <= ssra_pkg::SETUP_TICKS_RESET;
        end
        else if (cfg.write_enable)
        begin
            unique case (cfg.index)
                ssra_pkg::CFG_EDGE_TICKS:  edge_ticks_reg  <= cfg.data;
                ssra_pkg::CFG_SETUP_TICKS: setup_ticks_reg <= cfg.data;
                default:                   edge_ticks_reg  <= edge_ticks_reg;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> sv/serial_switch_register_access_unit.sv
// An accepted input transfer is queued, then its result is registered in the back end.
// Throughput: one item per cycle while neither the queue nor the output is stalled.
// A queue between the classifier and the sequencer lets each side stall on its own.
// Reset (asynchronous, active low): sequencer idle, queue empty, no result pending,
// edge_ticks returns to 3 and setup_ticks to 1.
`default_nettype none

module serial_switch_register_access_unit #(
    parameter int QUEUE_DEPTH = ssra_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic        table_select,
    input  wire logic [7:0]  reg_addr,
    input  wire logic [15:0] write_data,
    input  wire logic        data_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             chip_select,
    output logic             serial_clock,
    output logic             data_out,
    output logic             data_out_enable,
    output logic             pins_enable,
    output logic             busy_res,
    output logic             done_res,
    output logic [31:0]      read_data,
    output logic             rejected
);

    ssra_pkg::cfg_write_t cfg;
    ssra_pkg::entry_t     head;
    ssra_pkg::result_t    res;
    logic                 head_valid;
    logic                 pop;

    assign cfg.write_enable = cfg_write_enable;
    assign cfg.index        = cfg_index;
    assign cfg.data         = cfg_data;

    // Classifier and queue.
    ssra_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .table_select (table_select),
        .reg_addr     (reg_addr),
        .write_data   (write_data),
        .data_in      (data_in),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    // Pin sequencer.
    ssra_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res        (res)
    );

    // Result fields.
    assign chip_select     = res.chip_select;
    assign serial_clock    = res.serial_clock;
    assign data_out        = res.data_out;
    assign data_out_enable = res.data_out_enable;
    assign pins_enable     = res.pins_enable;
    assign busy_res        = res.busy_res;
    assign done_res        = res.done_res;
    assign read_data       = res.read_data;
    assign rejected        = res.rejected;

    // A completing tick belongs to a running sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> busy_res)
        else $error("done without busy");

    // A released data pin always reads low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !data_out_enable) |-> !data_out)
        else $error("data out high while released");

    // An idle tick drives nothing and reports nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |->
        (!pins_enable && !chip_select && !serial_clock && !done_res
         && !rejected && read_data == 32'd0))
        else $error("idle result not all zero");

    // Read data appears only on a completing tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (read_data == 32'd0))
        else $error("read data outside completion");

endmodule

`default_nettype wire
